// ----- rtl/ps2mi_pkg.sv -----
// shared types, script rom and constants for the ps2 mouse init sequencer
package ps2mi_pkg;

    localparam int          POS_W       = 5;
    localparam int          CNT_W       = 7;
    localparam int          TIMEOUT_W   = 16;
    localparam int          APB_ADDR_W  = 3;
    localparam int          APB_DATA_W  = 32;

    localparam logic [7:0]  AWAIT_FLAG  = 8'h80;
    localparam logic [POS_W-1:0] POS_LAST = 5'd31;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd175;

    // register index, taken from paddr[2]
    localparam logic        REG_REPLY_TIMEOUT = 1'b0;

    // reset, set wheel-mode sample rates, read id, enable reporting
    localparam logic [7:0] SCRIPT_ROM [0:31] = '{
        8'h01, 8'hff, 8'h82, 8'h08, 8'hf3, 8'd200, 8'hf3, 8'd100,
        8'hf3, 8'd80, 8'hf2, 8'h01, 8'h81, 8'h01, 8'hf4, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef struct packed {
        logic restart;
        logic rx_available;
    } in_word_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_taken;
        logic       flush_rx;
        logic       done_res;
    } out_word_t;

    // entries at or past the script length read as zero
    function automatic logic [7:0] rom_read(input logic [POS_W-1:0] addr,
                                            input logic [POS_W-1:0] len);
        logic [7:0] val;
        val = 8'h00;
        if (addr < len) begin
            val = SCRIPT_ROM[addr];
        end
        return val;
    endfunction

endpackage

// ----- rtl/ps2mi_apb_regs.sv -----
// apb configuration register holding the reply timeout
module ps2mi_apb_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ps2mi_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ps2mi_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ps2mi_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    output logic [ps2mi_pkg::TIMEOUT_W-1:0]     reply_timeout
);

    logic [ps2mi_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [ps2mi_pkg::TIMEOUT_W-1:0] timeout_next;
    logic                            wr_en;
    logic                            hit;

    assign pready = 1'b1;
    assign hit    = (paddr[2] == ps2mi_pkg::REG_REPLY_TIMEOUT);
    assign wr_en  = psel && penable && pwrite && pready && hit;

    always_comb begin
        timeout_next = timeout_reg;
        if (wr_en) begin
            timeout_next = pwdata[ps2mi_pkg::TIMEOUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= ps2mi_pkg::TIMEOUT_RESET;
        end else begin
            timeout_reg <= timeout_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (hit) begin
            prdata = {{(ps2mi_pkg::APB_DATA_W-ps2mi_pkg::TIMEOUT_W){1'b0}}, timeout_reg};
        end
    end

    assign reply_timeout = timeout_reg;

endmodule

// ----- rtl/ps2mi_step.sv -----
// script state registers and the per-slot next-state logic
module ps2mi_step #(
    parameter int SCRIPT_LEN = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            fire,
    input  ps2mi_pkg::in_word_t             in_word,
    input  logic [ps2mi_pkg::TIMEOUT_W-1:0] reply_timeout,
    output ps2mi_pkg::out_word_t            out_word
);

    localparam logic [ps2mi_pkg::POS_W-1:0] LenW = ps2mi_pkg::POS_W'(SCRIPT_LEN);

    logic [ps2mi_pkg::POS_W-1:0]     pos_reg,   pos_next;
    logic [ps2mi_pkg::CNT_W-1:0]     send_reg,  send_next;
    logic [ps2mi_pkg::CNT_W-1:0]     await_reg, await_next;
    logic [ps2mi_pkg::TIMEOUT_W-1:0] wait_reg,  wait_next;

    logic [ps2mi_pkg::POS_W-1:0]     pos_cur;
    logic [ps2mi_pkg::POS_W-1:0]     pos_inc;
    logic [7:0]                      rom_byte;
    logic [ps2mi_pkg::CNT_W-1:0]     await_mid;

    assign pos_cur  = in_word.restart ? '0 : pos_reg;
    assign pos_inc  = (pos_cur == ps2mi_pkg::POS_LAST) ? pos_cur : pos_cur + 1'b1;
    assign rom_byte = ps2mi_pkg::rom_read(pos_cur, LenW);

    always_comb begin
        pos_next   = pos_cur;
        send_next  = send_reg;
        await_next = await_reg;
        wait_next  = wait_reg;
        await_mid  = await_reg;
        out_word   = '0;

        if (pos_cur == '0) begin
            // start of script: flush and load first send count
            out_word.flush_rx = 1'b1;
            send_next  = rom_byte[ps2mi_pkg::CNT_W-1:0];
            await_next = '0;
            pos_next   = ps2mi_pkg::POS_W'(1);
        end else if (await_reg != '0) begin
            if (in_word.rx_available) begin
                out_word.rx_taken = 1'b1;
                await_mid = await_reg - 1'b1;
            end else if (wait_reg <= ps2mi_pkg::TIMEOUT_W'(1)) begin
                wait_next = '0;
                pos_next  = '0;
            end else begin
                wait_next = wait_reg - 1'b1;
            end
            await_next = await_mid;
            if (send_reg == '0 && await_mid == '0) begin
                pos_next = pos_inc;
                if ((rom_byte & ps2mi_pkg::AWAIT_FLAG) != 8'h00) begin
                    await_next = rom_byte[ps2mi_pkg::CNT_W-1:0];
                end else begin
                    send_next = rom_byte[ps2mi_pkg::CNT_W-1:0];
                end
            end
        end else if (send_reg != '0) begin
            out_word.tx_valid = 1'b1;
            out_word.tx_byte  = rom_byte;
            pos_next   = pos_inc;
            send_next  = send_reg - 1'b1;
            await_next = ps2mi_pkg::CNT_W'(1);
            wait_next  = reply_timeout;
        end

        out_word.done_res = (pos_next != '0) && (send_next == '0) && (await_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            send_reg  <= '0;
            await_reg <= '0;
            wait_reg  <= '0;
        end else if (fire) begin
            pos_reg   <= pos_next;
            send_reg  <= send_next;
            await_reg <= await_next;
            wait_reg  <= wait_next;
        end
    end

endmodule

// ----- rtl/ps2_mouse_init_script_sequencer_top.sv -----
// top level of the ps2 wheel mouse init script sequencer
// Each input word is one poll slot (nominally 20 ms) carrying a restart flag
// and whether a received byte is waiting; each slot yields exactly one result
// word telling whether to send a script byte, consume one received byte,
// flush the receive buffer, and whether the script has finished. A slot is
// captured in an input register, evaluated by the step logic against the
// script rom and counters, and the result lands in an output register, so
// one slot is accepted every clock cycle unless a stalled result has filled
// both registers. The reply timeout is an apb register at address 0 (reset
// 175 slots); write it only while no slot is in flight.
module ps2_mouse_init_script_sequencer_top #(
    parameter int SCRIPT_LEN = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // slot input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ps2mi_pkg::in_word_t                 s_data,
    // result output
    output logic                                m_valid,
    input  logic                                m_ready,
    output ps2mi_pkg::out_word_t                m_data,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ps2mi_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ps2mi_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ps2mi_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    logic                            in_valid_reg, in_valid_next;
    ps2mi_pkg::in_word_t             in_data_reg;
    logic                            out_valid_reg, out_valid_next;
    ps2mi_pkg::out_word_t            out_data_reg;
    ps2mi_pkg::out_word_t            step_word;
    logic [ps2mi_pkg::TIMEOUT_W-1:0] reply_timeout;
    logic                            fire;
    logic                            s_take;

    ps2mi_apb_regs u_regs (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .reply_timeout (reply_timeout)
    );

    // step fires when a slot is held and the output register can take it
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign s_take  = s_valid && s_ready;

    ps2mi_step #(
        .SCRIPT_LEN (SCRIPT_LEN)
    ) u_step (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .in_word       (in_data_reg),
        .reply_timeout (reply_timeout),
        .out_word      (step_word)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            out_data_reg <= step_word;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ----- rtl/ps2mi_checker.sv -----
// port-level checker for the sequencer, bound to the top level
module ps2mi_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  ps2mi_pkg::out_word_t m_data
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // a slot never both sends and consumes
    a_tx_rx_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.tx_valid |-> !m_data.rx_taken && !m_data.done_res)
        else $error("send slot also consumed a byte or reported done");

    // the flush slot does nothing else
    a_flush_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.flush_rx |->
            !m_data.tx_valid && !m_data.rx_taken && !m_data.done_res)
        else $error("flush slot did other work");

    // no byte value without a send
    a_tx_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.tx_valid |-> m_data.tx_byte == 8'h00)
        else $error("tx byte set without send");

endmodule

bind ps2_mouse_init_script_sequencer_top ps2mi_checker u_ps2mi_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- verif/ps2_mouse_init_script_sequencer_top_tb.sv -----
// self-checking testbench for the ps2 wheel mouse init script sequencer
`timescale 1ns / 1ps

module ps2_mouse_init_script_sequencer_top_tb;

    localparam int SCRIPT_LEN = 16;
    localparam int CLK_PERIOD = 12;
    localparam int RESET_CYCLES = 12;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int NUM_PHASES = 8;

    // register byte address
    localparam logic [ps2mi_pkg::APB_ADDR_W-1:0] ADDR_REPLY_TIMEOUT = '0;

    // mirrors the script walk and holds the result words still to come
    class slot_scoreboard;
        logic [ps2mi_pkg::TIMEOUT_W-1:0] timeout_slots;
        logic [ps2mi_pkg::POS_W-1:0]     script_pos;
        logic [ps2mi_pkg::CNT_W-1:0]     send_left;
        logic [ps2mi_pkg::CNT_W-1:0]     await_left;
        logic [ps2mi_pkg::TIMEOUT_W-1:0] wait_slots;
        ps2mi_pkg::out_word_t            expected_q[$];
        int                              mismatches;

        function void reset_state();
            timeout_slots = ps2mi_pkg::TIMEOUT_RESET;
            script_pos    = '0;
            send_left     = '0;
            await_left    = '0;
            wait_slots    = '0;
            expected_q.delete();
        endfunction

        function void set_timeout(logic [ps2mi_pkg::TIMEOUT_W-1:0] v);
            timeout_slots = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [7:0] script_byte(logic [ps2mi_pkg::POS_W-1:0] addr);
            if (addr < SCRIPT_LEN) begin
                return ps2mi_pkg::SCRIPT_ROM[addr];
            end
            return 8'h00;
        endfunction

        function void step_pos();
            if (script_pos != ps2mi_pkg::POS_LAST) begin
                script_pos = script_pos + 1'b1;
            end
        endfunction

        // one poll slot of the sequencer
        function void note_slot(ps2mi_pkg::in_word_t w);
            ps2mi_pkg::out_word_t r;
            logic [7:0]           next_byte;
            r = '0;
            if (w.restart) begin
                script_pos = '0;
            end
            if (script_pos == '0) begin
                // start slot: flush, load first send count
                r.flush_rx = 1'b1;
                next_byte  = script_byte('0);
                send_left  = next_byte[ps2mi_pkg::CNT_W-1:0];
                await_left = '0;
                script_pos = 5'd1;
            end else if (await_left != '0) begin
                if (w.rx_available) begin
                    r.rx_taken = 1'b1;
                    await_left = await_left - 1'b1;
                end else if (wait_slots <= 16'd1) begin
                    // reply timed out, back to the start next slot
                    wait_slots = '0;
                    script_pos = '0;
                end else begin
                    wait_slots = wait_slots - 1'b1;
                end
                if (send_left == '0 && await_left == '0) begin
                    next_byte = script_byte(script_pos);
                    step_pos();
                    if ((next_byte & ps2mi_pkg::AWAIT_FLAG) != 8'h00) begin
                        await_left = next_byte[ps2mi_pkg::CNT_W-1:0];
                    end else begin
                        send_left = next_byte[ps2mi_pkg::CNT_W-1:0];
                    end
                end
            end else if (send_left != '0) begin
                r.tx_valid = 1'b1;
                r.tx_byte  = script_byte(script_pos);
                step_pos();
                send_left  = send_left - 1'b1;
                await_left = 7'd1;
                wait_slots = timeout_slots;
            end
            r.done_res = (script_pos != '0 && send_left == '0 && await_left == '0);
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t ns: %s mismatch, expected %0h actual %0h",
                         $time, name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_result(ps2mi_pkg::out_word_t got);
            ps2mi_pkg::out_word_t want;
            if (expected_q.size() == 0) begin
                $display("%0t ns: unexpected result word, expected none actual %0h",
                         $time, got);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
            compare_field("tx_byte",  want.tx_byte,      got.tx_byte);
            compare_field("rx_taken", 8'(want.rx_taken), 8'(got.rx_taken));
            compare_field("flush_rx", 8'(want.flush_rx), 8'(got.flush_rx));
            compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
        endfunction
    endclass

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // slot channel
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    ps2mi_pkg::in_word_t  s_data  = '0;

    // result channel
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    ps2mi_pkg::out_word_t m_data;

    // apb port
    logic                             psel    = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite  = 1'b0;
    logic [ps2mi_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [ps2mi_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [ps2mi_pkg::APB_DATA_W-1:0] prdata;
    logic                             pready;

    // idle percentages and the hold-off request, set by the main sequence and read by the drivers
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    bit          hold_req    = 1'b0;
    int          hold_left   = 0;

    slot_scoreboard sb;

    ps2_mouse_init_script_sequencer_top #(
        .SCRIPT_LEN(SCRIPT_LEN)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever begin
            #(CLK_PERIOD / 2) aclk = ~aclk;
        end
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end

    // monitor: both handshakes sampled at the edge, before any driver update lands
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_slot(s_data);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_data);
            end
        end
    end

    // result side: random stalls, or a long counted hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready   <= 1'b0;
                hold_left  = hold_left - 1;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                hold_left  = HOLD_OFF_CYCLES - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // offer one slot word, after a random gap; valid stays up between back-to-back words
    task automatic send_slot(input bit restart, input bit rx_available);
        int gap;
        gap = 0;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid              <= 1'b1;
        s_data.restart       <= restart;
        s_data.rx_available  <= rx_available;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    // stop offering and let every expected word come out
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [ps2mi_pkg::APB_ADDR_W-1:0] addr,
                             input logic [ps2mi_pkg::APB_DATA_W-1:0] data);
        // setup cycle
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        // access cycle
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [ps2mi_pkg::APB_ADDR_W-1:0] addr,
                                  input logic [ps2mi_pkg::APB_DATA_W-1:0] want);
        logic [ps2mi_pkg::APB_DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            $display("%0t ns: register readback mismatch, expected %0h actual %0h",
                     $time, want, got);
            sb.mismatches++;
        end
    endtask

    // block is idle here; write the timeout, mirror it and read it back
    task automatic set_reply_timeout(input logic [ps2mi_pkg::TIMEOUT_W-1:0] slots);
        apb_write(ADDR_REPLY_TIMEOUT,
                  {{(ps2mi_pkg::APB_DATA_W-ps2mi_pkg::TIMEOUT_W){1'b0}}, slots});
        sb.set_timeout(slots);
        apb_read_check(ADDR_REPLY_TIMEOUT,
                       {{(ps2mi_pkg::APB_DATA_W-ps2mi_pkg::TIMEOUT_W){1'b0}}, slots});
    endtask

    // main sequence
    initial begin
        logic [ps2mi_pkg::TIMEOUT_W-1:0] phase_timeout [NUM_PHASES];
        int unsigned                     phase_rx_pct  [NUM_PHASES];
        bit                              restart_bit;
        bit                              rx_bit;

        phase_timeout = '{16'd175, 16'd1, 16'd65535, 16'd2, 16'd0, 16'd3, 16'd8, 16'd65535};
        phase_rx_pct  = '{85, 70, 95, 80, 90, 60, 85, 50};

        sb = new();
        sb.mismatches = 0;
        sb.reset_state();

        // synchronous reset, held once at the start
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset value of the timeout register
        apb_read_check(ADDR_REPLY_TIMEOUT,
                       {{(ps2mi_pkg::APB_DATA_W-ps2mi_pkg::TIMEOUT_W){1'b0}},
                        ps2mi_pkg::TIMEOUT_RESET});

        // directed: start slot ignores a waiting byte
        send_slot(1'b0, 1'b1);
        // first byte goes out, then an empty slot counts the reply timer down
        send_slot(1'b0, 1'b0);
        send_slot(1'b0, 1'b0);
        // ack, then the two extra replies, then into the send group
        send_slot(1'b0, 1'b1);
        send_slot(1'b0, 1'b1);
        send_slot(1'b0, 1'b1);
        send_slot(1'b0, 1'b1);
        send_slot(1'b0, 1'b1);
        // restart in the middle of the group, twice in a row
        send_slot(1'b1, 1'b1);
        send_slot(1'b1, 1'b0);
        drain_results();

        // shortest timeout: one empty slot after a send restarts the script
        set_reply_timeout(16'd1);
        send_slot(1'b0, 1'b0);
        send_slot(1'b0, 1'b0);
        send_slot(1'b0, 1'b0);
        send_slot(1'b0, 1'b1);
        drain_results();

        // zero timeout register behaves like an immediate timeout
        set_reply_timeout(16'd0);
        send_slot(1'b1, 1'b0);
        send_slot(1'b0, 1'b0);
        send_slot(1'b0, 1'b0);
        send_slot(1'b0, 1'b0);
        send_slot(1'b0, 1'b0);
        drain_results();

        // random phases: mostly acknowledging slots, some noise
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_reply_timeout(phase_timeout[p]);
            if (p < 3) begin
                tx_idle_pct = 13;
                rx_idle_pct = 80;
            end else if (p < 6) begin
                tx_idle_pct = 80;
                rx_idle_pct = 13;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if ($urandom_range(99) < 85) begin
                    // well-formed: rare restarts, replies at the phase rate
                    restart_bit = ($urandom_range(99) < 2);
                    rx_bit      = ($urandom_range(99) < phase_rx_pct[p]);
                end else begin
                    restart_bit = 1'($urandom_range(1));
                    rx_bit      = 1'($urandom_range(1));
                end
                // sender pause until the pipe is empty
                if (p == 1 && i == ITEMS_PER_PHASE / 2) begin
                    s_valid <= 1'b0;
                    while (sb.pending() != 0) begin
                        @(posedge aclk);
                    end
                end
                // long receiver hold-off while words keep coming
                if (p == 6 && i == ITEMS_PER_PHASE / 4) begin
                    hold_req = 1'b1;
                end
                send_slot(restart_bit, rx_bit);
            end
            drain_results();
        end

        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ps2mi_pkg.sv
rtl/ps2mi_apb_regs.sv
rtl/ps2mi_step.sv
rtl/ps2_mouse_init_script_sequencer_top.sv
rtl/ps2mi_checker.sv
verif/ps2_mouse_init_script_sequencer_top_tb.sv
